// File: rtl/scf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// scf_pkg
// Shared types, constants and the CRC-8 byte update for the command frame
// encoder.
// ---------------------------------------------------------------------------
package scf_pkg;

  localparam int unsigned ValueW  = 16;
  localparam int unsigned RegW    = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned ProdW   = RegW + ValueW;      // signed product width
  localparam int unsigned SumW    = ProdW + 1;          // product plus offset
  localparam int unsigned FracW   = 16;                 // Q16.16 fraction bits

  localparam logic [ByteW-1:0] FRAME_FLAG = 8'h7E;
  localparam logic [ByteW-1:0] FRAME_PAD  = 8'h00;
  localparam logic [ByteW-1:0] CRC_POLY   = 8'h31;
  localparam logic [ByteW-1:0] CRC_INIT   = 8'hFF;
  localparam logic [ByteW-1:0] CRC_TOPBIT = 8'h80;

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_SERVO_GAIN   = 2'd0;
  localparam logic [IdxW-1:0] REG_SERVO_OFFSET = 2'd1;
  localparam logic [IdxW-1:0] REG_STEP_GAIN    = 2'd2;
  localparam logic [IdxW-1:0] REG_STEP_OFFSET  = 2'd3;

  // Position of a byte within the six-byte frame
  typedef enum logic [2:0] {
    POS_OPEN  = 3'd0,
    POS_SERVO = 3'd1,
    POS_STEP  = 3'd2,
    POS_PAD   = 3'd3,
    POS_CRC   = 3'd4,
    POS_CLOSE = 3'd5
  } frame_pos_e;

  // One queued command: the two scaled bytes
  typedef struct packed {
    logic [ByteW-1:0] step_byte;
    logic [ByteW-1:0] servo_byte;
  } scf_entry_t;

  // Queue status seen by the producer and the consumer
  typedef struct packed {
    logic full;
    logic not_empty;
  } scf_qstat_t;

  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                    input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < ByteW; i++) begin
      if ((c & CRC_TOPBIT) != '0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/scaled_command_frame_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// scaled_command_frame_encoder
// Scales servo and step commands to bytes and sends each pair as a
// six-byte CRC-8 protected frame.
// ---------------------------------------------------------------------------
//  channel | dir | transfer        | payload
//  s_axis  | in  | tvalid & tready | tdata: servo_value[15:0], step_value[31:16]
//  m_axis  | out | tvalid & tready | tdata: frame_byte[7:0]; tlast: frame_last
//  cfg     | in  | cfg_we_i        | cfg_idx_i selects gain/offset, cfg_wdata_i
//
// The byte serializer sends one output byte per cycle while m_axis_tready stays
// high and a command is queued. After the input transaction a command passes
// the multiply stage, then the queue, then the output register. A two-entry
// queue lets the input side keep accepting while the output stalls. Reset is
// asynchronous, active low; the registers return to gain 1.0 and offset 0.
module scaled_command_frame_encoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // servo_value[15:0], step_value[31:16]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // frame_byte[7:0]
  output logic              m_axis_tlast    // frame_last
);
  import scf_pkg::*;

  scf_qstat_t qstat;
  scf_entry_t push_entry;
  scf_entry_t head_entry;
  logic       push;
  logic       pop;

  scf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .servo_value_i (s_axis_tdata[15:0]),
    .step_value_i  (s_axis_tdata[31:16]),
    .qstat_i       (qstat),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  scf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .qstat_o (qstat)
  );

  scf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_entry),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// File: rtl/scf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// scf_front
// Holds the gain/offset registers, accepts commands, multiplies in one
// registered stage, then adds, truncates and saturates into the queue.
// ---------------------------------------------------------------------------
module scf_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [scf_pkg::IdxW-1:0]    cfg_idx_i,
  input  wire logic [scf_pkg::RegW-1:0]    cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [scf_pkg::ValueW-1:0]  servo_value_i,
  input  wire logic [scf_pkg::ValueW-1:0]  step_value_i,
  input  wire scf_pkg::scf_qstat_t         qstat_i,
  output logic                             push_o,
  output scf_pkg::scf_entry_t              entry_o
);
  import scf_pkg::*;

  logic [RegW-1:0] servo_gain_q, servo_offset_q, step_gain_q, step_offset_q;

  logic                    prod_valid_q, prod_valid_d;
  logic signed [ProdW-1:0] servo_prod_q, step_prod_q;
  logic signed [ProdW-1:0] servo_prod_d, step_prod_d;
  logic                    advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_gain_q   <= RegW'(32'h0001_0000);
      servo_offset_q <= '0;
      step_gain_q    <= RegW'(32'h0001_0000);
      step_offset_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SERVO_GAIN:   servo_gain_q   <= cfg_wdata_i;
        REG_SERVO_OFFSET: servo_offset_q <= cfg_wdata_i;
        REG_STEP_GAIN:    step_gain_q    <= cfg_wdata_i;
        REG_STEP_OFFSET:  step_offset_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  function automatic logic [ByteW-1:0] sat_byte(input logic signed [ProdW-1:0] prod,
                                                input logic [RegW-1:0]         offset);
    logic signed [SumW-1:0] sum;
    sum = SumW'(prod) + SumW'($signed(offset));
    if (sum[SumW-1]) begin
      return '0;
    end else if (sum[SumW-2:FracW+ByteW] != '0) begin
      return '1;
    end else begin
      return sum[FracW+ByteW-1:FracW];
    end
  endfunction

  // Stage empties into the queue whenever there is room
  assign push_o     = prod_valid_q && !qstat_i.full;
  assign advance    = !prod_valid_q || !qstat_i.full;
  assign in_ready_o = advance;

  always_comb begin
    prod_valid_d = prod_valid_q;
    if (advance) begin
      prod_valid_d = in_valid_i;
    end
    servo_prod_d = ProdW'($signed(servo_gain_q) * $signed({1'b0, servo_value_i}));
    step_prod_d  = ProdW'($signed(step_gain_q) * $signed({1'b0, step_value_i}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= prod_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      servo_prod_q <= servo_prod_d;
      step_prod_q  <= step_prod_d;
    end
  end

  always_comb begin
    entry_o.servo_byte = sat_byte(servo_prod_q, servo_offset_q);
    entry_o.step_byte  = sat_byte(step_prod_q, step_offset_q);
  end

endmodule
`default_nettype wire

// File: rtl/scf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// scf_queue
// Two-entry queue of scaled commands between the front and the framer.
// ---------------------------------------------------------------------------
module scf_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire scf_pkg::scf_entry_t  entry_i,
  input  wire logic                 pop_i,
  output scf_pkg::scf_entry_t       head_o,
  output scf_pkg::scf_qstat_t       qstat_o
);
  import scf_pkg::*;

  scf_entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o            = mem_q[rd_ptr_q];
  assign qstat_o.full      = count_q[1];
  assign qstat_o.not_empty = (count_q != '0);

endmodule
`default_nettype wire

// File: rtl/scf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// scf_back
// Frames the queue head into six bytes behind an output register, one per
// cycle unless the output stalls, running the CRC-8 over the leading bytes.
// ---------------------------------------------------------------------------
module scf_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire scf_pkg::scf_entry_t       head_i,
  input  wire scf_pkg::scf_qstat_t       qstat_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [scf_pkg::ByteW-1:0]      out_byte_o,
  output logic                           out_last_o
);
  import scf_pkg::*;

  localparam logic [ByteW-1:0] CrcAfterFlag = crc8_update(CRC_INIT, FRAME_FLAG);

  frame_pos_e       pos_q, pos_d;
  logic [ByteW-1:0] crc_q, crc_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             load;

  // Load while a command is queued and the output register is free or draining
  assign load  = qstat_i.not_empty && (!out_valid_q || out_ready_i);
  assign pop_o = load && (pos_q == POS_CLOSE);

  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      out_last_d  = 1'b0;
      unique case (pos_q)
        POS_OPEN: begin
          out_byte_d = FRAME_FLAG;
          crc_d      = CrcAfterFlag;
          pos_d      = POS_SERVO;
        end
        POS_SERVO: begin
          out_byte_d = head_i.servo_byte;
          crc_d      = crc8_update(crc_q, head_i.servo_byte);
          pos_d      = POS_STEP;
        end
        POS_STEP: begin
          out_byte_d = head_i.step_byte;
          crc_d      = crc8_update(crc_q, head_i.step_byte);
          pos_d      = POS_PAD;
        end
        POS_PAD: begin
          out_byte_d = FRAME_PAD;
          crc_d      = crc8_update(crc_q, FRAME_PAD);
          pos_d      = POS_CRC;
        end
        POS_CRC: begin
          out_byte_d = crc_q;
          pos_d      = POS_CLOSE;
        end
        POS_CLOSE: begin
          out_byte_d = FRAME_FLAG;
          out_last_d = 1'b1;
          pos_d      = POS_OPEN;
        end
        default: begin
          pos_d = POS_OPEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_OPEN;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q      <= crc_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire
